### design/zp2dconv_pkg.sv
// Package for the zero-padded 2D convolution block: payload types, register
// indices, fixed field widths and the dimension clamp. Depends on nothing.
`default_nettype none

package zp2dconv_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 12;
    localparam int FRAC_W     = 12;
    localparam int PROD_W     = PIX_W + COEF_W;
    localparam int DIM_W      = 11;
    localparam int POS_W      = 10;
    localparam int KROW_W     = 60;
    localparam int KROW_NUM   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int CNT_W      = FIFO_AW + 1;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [DIM_W-1:0]      t_dim;
    typedef logic [KROW_NUM-1:0][KROW_W-1:0] t_kernel;

    localparam t_cfg_idx REG_IMAGE_WIDTH  = 3'd0;
    localparam t_cfg_idx REG_IMAGE_HEIGHT = 3'd1;
    localparam t_cfg_idx REG_KROW_ZERO    = 3'd2;
    localparam t_cfg_idx REG_KROW_ONE     = 3'd3;
    localparam t_cfg_idx REG_KROW_TWO     = 3'd4;
    localparam t_cfg_idx REG_KROW_THREE   = 3'd5;
    localparam t_cfg_idx REG_KROW_FOUR    = 3'd6;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_last;
    } t_pix_out;

    // Position and flags that travel alongside a pixel through the datapath.
    typedef struct packed {
        logic             emit;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_last;
    } t_meta;

    // Zero is raised to one, anything above the maximum is cut to the maximum.
    function automatic t_dim clamp_dim(input t_dim v, input t_dim maxv);
        t_dim res;
        if (v == '0) begin
            res = t_dim'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/zp2dconv_if.sv
// Valid/ready stream interface used for the pixel input and result channels.
// The payload type is given per instance; depends on nothing.
`default_nettype none

interface zp2dconv_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/zp2dconv_line_store.sv
// Line store: one word per image column holding the previous KSIZE-1 rows,
// read on acceptance and written back shifted in the following cycle. Uses zp2dconv_pkg.
`default_nettype none

module zp2dconv_line_store #(
    parameter int KSIZE     = 3,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]              i_addr,
    input  logic [zp2dconv_pkg::PIX_W-1:0]            i_pixel,
    output logic [KSIZE*zp2dconv_pkg::PIX_W-1:0]      o_column
);
    import zp2dconv_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WORD_W = (KSIZE - 1) * PIX_W;

    logic [WORD_W-1:0] r_mem [MAX_WIDTH];
    logic [WORD_W-1:0] r_rdata;
    logic              r_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [PIX_W-1:0]  r_pixel;

    // Oldest row in the lowest slot, the new pixel on top.
    assign o_column = {r_pixel, r_rdata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_rd_en;
        end
    end

    // Consecutive transactions never address the same column, as a grid row
    // is at least two columns long, so the write-back needs no forwarding.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata   <= r_mem[i_addr];
            r_wr_addr <= i_addr;
            r_pixel   <= i_pixel;
        end
        if (r_wr_pend) begin
            r_mem[r_wr_addr] <= o_column[KSIZE*PIX_W-1:PIX_W];
        end
    end

endmodule

`default_nettype wire

### design/zp2dconv_mac.sv
// Window register and pipelined multiply-add: window, products, row sums,
// then total with shift and saturation. Uses zp2dconv_pkg.
`default_nettype none

module zp2dconv_mac #(
    parameter int KSIZE = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_shift,
    input  logic                                 i_first,
    input  logic                                 i_col_in,
    input  logic [KSIZE-1:0]                     i_row_ok,
    input  logic [KSIZE*zp2dconv_pkg::PIX_W-1:0] i_column,
    input  zp2dconv_pkg::t_meta                  i_meta,
    input  zp2dconv_pkg::t_kernel                i_kernel,
    output logic                                 o_valid,
    output zp2dconv_pkg::t_pix_out               o_data
);
    import zp2dconv_pkg::*;

    localparam int RS_W  = PROD_W + $clog2(KSIZE);
    localparam int SUM_W = PROD_W + $clog2(KSIZE * KSIZE);

    logic [PIX_W-1:0]  r_win  [KSIZE][KSIZE];
    logic [PROD_W-1:0] r_prod [KSIZE][KSIZE];
    logic [RS_W-1:0]   r_rsum [KSIZE];
    logic [RS_W-1:0]   w_rsum [KSIZE];
    logic [SUM_W-1:0]  w_total;
    logic [PIX_W-1:0]  w_pix;
    t_meta             r_s2_meta;
    t_meta             r_s3_meta;
    t_meta             r_s4_meta;
    logic              r_valid;
    t_pix_out          r_data;

    // Window shift; the first column of a grid row clears the older columns
    // so that positions left of the image read as zero.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int i = 0; i < KSIZE; i++) begin
                for (int j = 0; j < KSIZE - 1; j++) begin
                    r_win[i][j] <= i_first ? '0 : r_win[i][j+1];
                end
                r_win[i][KSIZE-1] <= (i_col_in && i_row_ok[i]) ?
                                     i_column[PIX_W*i +: PIX_W] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE; j++) begin
                r_prod[i][j] <= PROD_W'(r_win[i][j]) *
                                PROD_W'(i_kernel[i][COEF_W*j +: COEF_W]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < KSIZE; i++) begin
            w_rsum[i] = '0;
            for (int j = 0; j < KSIZE; j++) begin
                w_rsum[i] = w_rsum[i] + RS_W'(r_prod[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < KSIZE; i++) begin
            r_rsum[i] <= w_rsum[i];
        end
    end

    always_comb begin
        w_total = '0;
        for (int i = 0; i < KSIZE; i++) begin
            w_total = w_total + SUM_W'(r_rsum[i]);
        end
        if (w_total[SUM_W-1:FRAC_W+PIX_W] != '0) begin
            w_pix = '1;
        end else begin
            w_pix = w_total[FRAC_W +: PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_meta.emit <= 1'b0;
            r_s3_meta.emit <= 1'b0;
            r_s4_meta.emit <= 1'b0;
            r_valid        <= 1'b0;
        end else begin
            r_s2_meta <= i_meta;
            r_s3_meta <= r_s2_meta;
            r_s4_meta <= r_s3_meta;
            r_valid   <= r_s4_meta.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= '{pixel_out:  w_pix,
                    out_row:    r_s4_meta.out_row,
                    out_col:    r_s4_meta.out_col,
                    frame_last: r_s4_meta.frame_last};
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### design/zp2dconv_fifo.sv
// Small result queue that decouples the datapath from output back-pressure.
// Uses zp2dconv_pkg.
`default_nettype none

module zp2dconv_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  zp2dconv_pkg::t_pix_out           i_data,
    input  logic                             i_pop,
    output logic                             o_valid,
    output zp2dconv_pkg::t_pix_out           o_data,
    output logic [zp2dconv_pkg::CNT_W-1:0]   o_count
);
    import zp2dconv_pkg::*;

    t_pix_out           r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### design/zero_padded_2d_convolution.sv
// Zero-padded KSIZE x KSIZE convolution over an 8-bit raster stream.
// One pixel transaction per cycle while the result queue credit allows, set by the
// line store's single read and single write-back of one column word per cycle. A
// result is offered once the transaction that completes its window has passed stage
// one, the window, product, row-sum and output registers and the result queue. Reset is
// synchronous and clears control state only, never the line store: no clearing pass.
`default_nettype none

module zero_padded_2d_convolution #(
    parameter int KSIZE      = 3,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  zp2dconv_pkg::t_cfg_idx  i_cfg_idx,
    input  zp2dconv_pkg::t_cfg_data i_cfg_data,
    zp2dconv_stream_if.sink         i_pix,
    zp2dconv_stream_if.source       o_pix
);
    import zp2dconv_pkg::*;

    localparam int RAD     = KSIZE / 2;
    localparam int COL_W   = $clog2(MAX_WIDTH + KSIZE);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + KSIZE);
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int RESET_W = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
    localparam int RESET_H = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;

    // Configuration. Dimensions are held already clamped to their legal range.
    logic [COL_W-1:0] r_width;
    logic [ROW_W-1:0] r_height;
    t_kernel          r_kernel;

    // Grid position of the next pixel transaction. The grid is the image
    // extended by RAD margin columns on the right and RAD margin rows below.
    logic [COL_W-1:0] r_gc;
    logic [ROW_W-1:0] r_gr;
    logic [COL_W-1:0] w_row_len;
    logic [ROW_W-1:0] w_col_len;
    logic             w_gc_last;
    logic             w_gr_last;
    logic             w_acc;
    logic             w_dim_wr;

    // Per-transaction decode made at acceptance.
    logic             w_col_in;
    logic [KSIZE-1:0] w_row_ok;
    logic [ROW_W:0]   w_gr_x;
    logic [PIX_W-1:0] w_pixel;
    t_meta            w_meta;

    // Stage one: the transaction whose line-store word is being read.
    logic             r_s1_valid;
    logic             r_s1_first;
    logic             r_s1_col_in;
    logic [KSIZE-1:0] r_s1_row_ok;
    t_meta            r_s1_meta;

    logic [KSIZE*PIX_W-1:0] w_column;
    logic                   w_mac_valid;
    t_pix_out               w_mac_data;
    logic [CNT_W-1:0]       w_fifo_count;
    logic [CNT_W-1:0]       r_inflight;
    logic [CNT_W:0]         w_credit_sum;
    logic                   w_credit_ok;

    assign w_row_len = r_width + COL_W'(RAD);
    assign w_col_len = r_height + ROW_W'(RAD);
    assign w_gc_last = (r_gc == w_row_len - COL_W'(1));
    assign w_gr_last = (r_gr == w_col_len - ROW_W'(1));
    assign w_dim_wr  = i_cfg_we &&
                       ((i_cfg_idx == REG_IMAGE_WIDTH) || (i_cfg_idx == REG_IMAGE_HEIGHT));

    // Configuration registers. A write of either dimension restarts the frame
    // at the top-left grid position; any partial frame is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= COL_W'(RESET_W);
            r_height <= ROW_W'(RESET_H);
            r_kernel <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH: begin
                    r_width <= COL_W'(clamp_dim(i_cfg_data[DIM_W-1:0], DIM_W'(MAX_WIDTH)));
                end
                REG_IMAGE_HEIGHT: begin
                    r_height <= ROW_W'(clamp_dim(i_cfg_data[DIM_W-1:0], DIM_W'(MAX_HEIGHT)));
                end
                REG_KROW_ZERO:  r_kernel[0] <= i_cfg_data[KROW_W-1:0];
                REG_KROW_ONE:   r_kernel[1] <= i_cfg_data[KROW_W-1:0];
                REG_KROW_TWO:   r_kernel[2] <= i_cfg_data[KROW_W-1:0];
                REG_KROW_THREE: r_kernel[3] <= i_cfg_data[KROW_W-1:0];
                REG_KROW_FOUR:  r_kernel[4] <= i_cfg_data[KROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Grid position counter, stepping in raster order and wrapping at the end
    // of the extended frame. A dimension write takes precedence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gc <= '0;
            r_gr <= '0;
        end else if (w_dim_wr) begin
            r_gc <= '0;
            r_gr <= '0;
        end else if (w_acc) begin
            if (w_gc_last) begin
                r_gc <= '0;
                r_gr <= w_gr_last ? '0 : r_gr + ROW_W'(1);
            end else begin
                r_gc <= r_gc + COL_W'(1);
            end
        end
    end

    // Decode of the incoming transaction. The column entering the window
    // covers grid rows r_gr-2*RAD up to r_gr; window row i is valid when that
    // image row lies between zero and the image height. Margin columns are
    // not stored and enter the window as zeros.
    always_comb begin
        w_gr_x   = {1'b0, r_gr};
        w_col_in = (r_gc < r_width);
        for (int i = 0; i < KSIZE; i++) begin
            w_row_ok[i] = ((w_gr_x + (ROW_W+1)'(i)) >= (ROW_W+1)'(2 * RAD)) &&
                          ((w_gr_x + (ROW_W+1)'(i)) <
                           ({1'b0, r_height} + (ROW_W+1)'(2 * RAD)));
        end
        // The newest row is valid exactly when the current grid row is in
        // the image, so margin rows store zeros.
        w_pixel           = w_row_ok[KSIZE-1] ? i_pix.data.pixel_in : '0;
        w_meta.emit       = w_acc && (r_gr >= ROW_W'(RAD)) && (r_gc >= COL_W'(RAD));
        w_meta.out_row    = POS_W'(r_gr - ROW_W'(RAD));
        w_meta.out_col    = POS_W'(r_gc - COL_W'(RAD));
        w_meta.frame_last = w_gr_last && w_gc_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_s1_meta.emit <= 1'b0;
        end else begin
            r_s1_valid <= w_acc;
            r_s1_meta  <= w_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first  <= (r_gc == '0);
        r_s1_col_in <= w_col_in;
        r_s1_row_ok <= w_row_ok;
    end

    zp2dconv_line_store #(
        .KSIZE     (KSIZE),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (w_acc && w_col_in),
        .i_addr   (r_gc[ADDR_W-1:0]),
        .i_pixel  (w_pixel),
        .o_column (w_column)
    );

    zp2dconv_mac #(
        .KSIZE (KSIZE)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (r_s1_valid),
        .i_first  (r_s1_first),
        .i_col_in (r_s1_col_in),
        .i_row_ok (r_s1_row_ok),
        .i_column (w_column),
        .i_meta   (r_s1_meta),
        .i_kernel (r_kernel),
        .o_valid  (w_mac_valid),
        .o_data   (w_mac_data)
    );

    // The datapath never stalls. A pixel transaction is taken only while the
    // result queue has room for every result still in the datapath plus one,
    // so every result leaving the datapath finds room in the result queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + CNT_W'(w_acc && w_meta.emit) - CNT_W'(w_mac_valid);
        end
    end

    assign w_credit_sum = {1'b0, r_inflight} + {1'b0, w_fifo_count};
    assign w_credit_ok  = (w_credit_sum < (CNT_W+1)'(FIFO_DEPTH));
    assign i_pix.ready  = w_credit_ok;
    assign w_acc        = i_pix.valid && w_credit_ok;

    zp2dconv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mac_valid),
        .i_data  (w_mac_data),
        .i_pop   (o_pix.ready),
        .o_valid (o_pix.valid),
        .o_data  (o_pix.data),
        .o_count (w_fifo_count)
    );

    // The credit scheme must never let the result queue overflow.
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_credit_sum <= (CNT_W+1)'(FIFO_DEPTH))
        else $error("result queue credit exceeded");

    // Every result leaving the datapath was counted in on acceptance.
    a_inflight_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_valid |-> (r_inflight != '0))
        else $error("result produced with no transaction in flight");

    // The grid position stays inside the extended frame.
    a_grid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gc < w_row_len) && (r_gr < w_col_len))
        else $error("grid position outside the extended frame");

endmodule

`default_nettype wire
